// ===== sv/ist_pkg.sv =====
// Package for the integer set table engine: sizes, codes, state enums,
// the store command and response structs and the slot address function.
// No dependencies.
`timescale 1ns / 1ps

package ist_pkg;

  localparam int CAPACITY    = 16;
  localparam int NUM_SETS    = 4;
  localparam int TOTAL_SLOTS = CAPACITY * NUM_SETS;

  localparam int REQ_W  = 3;
  localparam int SETF_W = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int MCNT_W = 5;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SLOT_AW = $clog2(TOTAL_SLOTS);

  typedef enum logic [REQ_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_UNION  = 3'd4,
    OP_INTER  = 3'd5,
    OP_DIFF   = 3'd6
  } req_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_NEXT,
    S_FETCH,
    S_RESP
  } seq_state_t;

  // what the current lookup is for
  typedef enum logic [1:0] {
    K_REQ,
    K_ELEM_A,
    K_ELEM_B
  } kind_t;

  typedef struct packed {
    logic [SLOT_AW-1:0] raddr;
    logic               wr;
    logic               inval;
    logic               clr;
    logic [SET_W-1:0]   cset;
    logic [SLOT_AW-1:0] waddr;
    logic [VAL_W-1:0]   wdata;
  } st_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] data;
  } st_rsp_t;

  typedef struct packed {
    logic              strobe;
    stat_t             status;
    logic [MCNT_W-1:0] count;
  } res_t;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [SET_W-1:0] s,
                                                    input logic [IDX_W-1:0] i);
    return SLOT_AW'(SLOT_AW'(s) * SLOT_AW'(CAPACITY) + SLOT_AW'(i));
  endfunction

endpackage

// ===== sv/ist_store.sv =====
// Slot store: value memory (one write, one registered read per cycle)
// plus per-slot valid flags. Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_store (
  input  logic             clk,
  input  logic             rst_n,
  input  ist_pkg::st_cmd_t cmd,
  output ist_pkg::st_rsp_t rsp
);
  import ist_pkg::*;

  logic [VAL_W-1:0]       mem [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] valid_r, valid_nxt;
  logic [VAL_W-1:0]       rdata_r;
  logic                   rvalid_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata_r <= mem[cmd.raddr];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clr) begin
      for (int i = 0; i < CAPACITY; i++) begin
        valid_nxt[slot_addr(cmd.cset, IDX_W'(i))] = 1'b0;
      end
    end
    if (cmd.inval) begin
      valid_nxt[cmd.waddr] = 1'b0;
    end
    if (cmd.wr) begin
      valid_nxt[cmd.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rvalid_r <= valid_r[cmd.raddr];
    end
  end

  assign rsp.valid = rvalid_r;
  assign rsp.data  = rdata_r;

endmodule

// ===== sv/ist_seq.sv =====
// Request sequencer: slot scans, read-modify-write of the slot store,
// per-set member counts and result status. Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ist_pkg::REQ_W-1:0]   req_type,
  input  logic [ist_pkg::SETF_W-1:0]  target_set,
  input  logic [ist_pkg::SETF_W-1:0]  source_a,
  input  logic [ist_pkg::SETF_W-1:0]  source_b,
  input  logic [ist_pkg::VAL_W-1:0]   value,
  output logic                        busy,
  output ist_pkg::st_cmd_t            st_cmd,
  input  ist_pkg::st_rsp_t            st_rsp,
  output ist_pkg::res_t               res
);
  import ist_pkg::*;

  seq_state_t          state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [REQ_W-1:0]    op_r, op_nxt;
  logic [SETF_W-1:0]   t_r, t_nxt, sa_r, sa_nxt, sb_r, sb_nxt;
  logic                t_ok_r, t_ok_nxt;
  logic [VAL_W-1:0]    key_r, key_nxt;
  stat_t               status_r, status_nxt;
  logic [CNT_W-1:0]    oi_r, oi_nxt, si_r, si_nxt;
  logic                pv_r, pv_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;
  logic                hit_r, hit_nxt, free_r, free_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]    cnt_r [NUM_SETS];
  logic [CNT_W-1:0]    cnt_nxt [NUM_SETS];

  logic [SET_W-1:0]    tset, scan_set;
  logic [SETF_W-1:0]   src_sel;
  logic                src_ok, b_ok, cnt_full, rsp_hit, take;
  logic [CNT_W-1:0]    cnt_t;

  assign tset     = SET_W'(t_r);
  assign src_sel  = (kind_r == K_ELEM_B) ? sb_r : sa_r;
  assign src_ok   = (int'(src_sel) < NUM_SETS) && (src_sel != t_r);
  assign b_ok     = (int'(sb_r) < NUM_SETS) && (sb_r != t_r);
  assign scan_set = (kind_r == K_ELEM_A) ? SET_W'(sb_r) : tset;
  assign cnt_t    = cnt_r[tset];
  assign cnt_full = cnt_t >= CNT_W'(CAPACITY);
  assign rsp_hit  = st_rsp.valid && (st_rsp.data == key_r);
  assign take     = (op_r == OP_UNION) || (op_r == OP_INTER && hit_r) ||
                    (op_r == OP_DIFF && !hit_r);
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    op_nxt       = op_r;
    t_nxt        = t_r;
    sa_nxt       = sa_r;
    sb_nxt       = sb_r;
    t_ok_nxt     = t_ok_r;
    key_nxt      = key_r;
    status_nxt   = status_r;
    oi_nxt       = oi_r;
    si_nxt       = si_r;
    pv_nxt       = pv_r;
    pidx_nxt     = pidx_r;
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    cnt_nxt      = cnt_r;
    st_cmd       = '0;
    res          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = req_type;
          t_nxt      = target_set;
          sa_nxt     = source_a;
          sb_nxt     = source_b;
          key_nxt    = value;
          status_nxt = ST_OK;
          t_ok_nxt   = int'(target_set) < NUM_SETS;
          kind_nxt   = K_REQ;
          oi_nxt     = '0;
          si_nxt     = '0;
          pv_nxt     = 1'b0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          if (!t_ok_nxt) begin
            state_nxt = S_RESP;
          end else begin
            unique case (req_type) inside
              OP_INSERT, OP_DELETE, OP_FIND: begin
                state_nxt = S_SCAN;
              end
              OP_CLEAR: begin
                st_cmd.clr                       = 1'b1;
                st_cmd.cset                      = SET_W'(target_set);
                cnt_nxt[SET_W'(target_set)]      = '0;
                state_nxt                        = S_RESP;
              end
              OP_UNION, OP_INTER, OP_DIFF: begin
                st_cmd.clr                       = 1'b1;
                st_cmd.cset                      = SET_W'(target_set);
                cnt_nxt[SET_W'(target_set)]      = '0;
                kind_nxt                         = K_ELEM_A;
                state_nxt                        = S_NEXT;
              end
              default: begin
                state_nxt = S_RESP;
              end
            endcase
          end
        end
      end

      // one slot read issued per cycle, compared in the next cycle
      S_SCAN: begin
        if (si_r < CNT_W'(CAPACITY)) begin
          st_cmd.raddr = slot_addr(scan_set, si_r[IDX_W-1:0]);
          pv_nxt       = 1'b1;
          pidx_nxt     = si_r[IDX_W-1:0];
          si_nxt       = si_r + CNT_W'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (rsp_hit) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pidx_r;
          end
          if (!st_rsp.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
          if (si_r == CNT_W'(CAPACITY)) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        unique case (kind_r)
          K_REQ: begin
            state_nxt = S_RESP;
            unique case (op_r) inside
              OP_INSERT: begin
                if (hit_r) begin
                  status_nxt = ST_MISS;
                end else if (cnt_full || !free_r) begin
                  status_nxt = ST_FULL;
                end else begin
                  st_cmd.wr     = 1'b1;
                  st_cmd.waddr  = slot_addr(tset, free_idx_r);
                  st_cmd.wdata  = key_r;
                  cnt_nxt[tset] = cnt_t + CNT_W'(1);
                  status_nxt    = ST_OK;
                end
              end
              OP_DELETE: begin
                if (hit_r) begin
                  st_cmd.inval = 1'b1;
                  st_cmd.waddr = slot_addr(tset, hit_idx_r);
                  if (cnt_t != '0) begin
                    cnt_nxt[tset] = cnt_t - CNT_W'(1);
                  end
                  status_nxt = ST_OK;
                end else begin
                  status_nxt = ST_MISS;
                end
              end
              default: begin
                status_nxt = hit_r ? ST_OK : ST_MISS;
              end
            endcase
          end
          K_ELEM_A, K_ELEM_B: begin
            state_nxt = S_NEXT;
            // target fills densely from slot 0 during a set operation
            if ((kind_r == K_ELEM_A && take) || (kind_r == K_ELEM_B && !hit_r)) begin
              if (cnt_full) begin
                status_nxt = ST_FULL;
              end else begin
                st_cmd.wr     = 1'b1;
                st_cmd.waddr  = slot_addr(tset, cnt_t[IDX_W-1:0]);
                st_cmd.wdata  = key_r;
                cnt_nxt[tset] = cnt_t + CNT_W'(1);
              end
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_NEXT: begin
        if ((oi_r < CNT_W'(CAPACITY)) && src_ok) begin
          st_cmd.raddr = slot_addr(SET_W'(src_sel), oi_r[IDX_W-1:0]);
          oi_nxt       = oi_r + CNT_W'(1);
          state_nxt    = S_FETCH;
        end else if (kind_r == K_ELEM_A && op_r == OP_UNION) begin
          kind_nxt = K_ELEM_B;
          oi_nxt   = '0;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_FETCH: begin
        if (!st_rsp.valid) begin
          state_nxt = S_NEXT;
        end else begin
          key_nxt  = st_rsp.data;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          si_nxt   = '0;
          pv_nxt   = 1'b0;
          if (kind_r == K_ELEM_B || (op_r != OP_UNION && b_ok)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_RESP: begin
        res.strobe = 1'b1;
        res.status = status_r;
        res.count  = t_ok_r ? MCNT_W'(cnt_t) : '0;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
      for (int s = 0; s < NUM_SETS; s++) begin
        cnt_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    op_r       <= op_nxt;
    t_r        <= t_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    t_ok_r     <= t_ok_nxt;
    key_r      <= key_nxt;
    status_r   <= status_nxt;
    oi_r       <= oi_nxt;
    si_r       <= si_nxt;
    pidx_r     <= pidx_nxt;
    hit_r      <= hit_nxt;
    free_r     <= free_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

endmodule

// ===== sv/integer_set_table_engine.sv =====
// Channel  | transfer when      | ports
// request  | start && !busy     | in_req_type, in_target_set, in_source_a, in_source_b, in_value
// result   | out_valid (1 cyc)  | out_status, out_member_count
//
// Insert, delete and find scan every slot of the target set (one slot read a cycle).
// Clear and unknown codes go straight to the result. Set operations read each source slot,
// and each member that needs a lookup in the other set scans that set first.
// busy drops in the strobe cycle; the next request may transfer there.
// Synchronous active-low reset empties all sets at once. Results cannot be stalled.
// Top level of the integer set table engine; depends on ist_pkg, ist_store, ist_seq.
`timescale 1ns / 1ps

module integer_set_table_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic        [ist_pkg::REQ_W-1:0]  in_req_type,
  input  logic        [ist_pkg::SETF_W-1:0] in_target_set,
  input  logic        [ist_pkg::SETF_W-1:0] in_source_a,
  input  logic        [ist_pkg::SETF_W-1:0] in_source_b,
  input  logic signed [ist_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  output logic        [ist_pkg::STAT_W-1:0] out_status,
  output logic        [ist_pkg::MCNT_W-1:0] out_member_count
);
  import ist_pkg::*;

  st_cmd_t           st_cmd;
  st_rsp_t           st_rsp;
  res_t              res;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [MCNT_W-1:0] out_count_r;

  ist_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (st_cmd),
    .rsp   (st_rsp)
  );

  ist_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .target_set (in_target_set),
    .source_a   (in_source_a),
    .source_b   (in_source_b),
    .value      (in_value),
    .busy       (busy),
    .st_cmd     (st_cmd),
    .st_rsp     (st_rsp),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.strobe;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= res.status;
    out_count_r  <= res.count;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_member_count = out_count_r;

endmodule

// ===== sv/ist_checker.sv =====
// Port-level checks for the integer set table engine, bound to the top level.
// Depends on ist_pkg and integer_set_table_engine.
`timescale 1ns / 1ps

module ist_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [ist_pkg::STAT_W-1:0]  out_status,
  input logic [ist_pkg::MCNT_W-1:0]  out_member_count
);
  import ist_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result strobe without end of busy");

  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_member_count == MCNT_W'(CAPACITY)))
    else $error("full status with target below capacity");

endmodule

bind integer_set_table_engine ist_checker u_ist_checker (.*);
